// File: rtl/core/glb_pkg.sv
// Shared types and constants for the line blur block.
package glb_pkg;

	localparam int SAMPLE_W = 8;
	localparam int HALF_W   = 4;   // half width register, also bounds the position, pad and result counts
	localparam int TAP_W    = 5;   // tap counter, up to 2*15 taps
	localparam int ACC_W    = 21;  // 30 taps * 255 * 255
	localparam int TOT_W    = 13;  // 30 taps * 255
	localparam int WGT_W    = 128;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH = 2'd2;

	localparam logic [HALF_W-1:0]     HALF_WIDTH_RST   = 4'd6;
	localparam logic [CFG_DATA_W-1:0] WEIGHTS_LOW_RST  = 64'd287063795161855;
	localparam logic [CFG_DATA_W-1:0] WEIGHTS_HIGH_RST = 64'd0;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                line_end;
	} in_beat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] blurred;
		logic                last_of_line;
	} out_beat_t;

	// Classified sample handed from front to engine
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                fill;   // first sample of a line: flood the window
		logic                last;   // line end: flush
		logic                emit;   // one result due (non-flush case)
		logic [HALF_W-1:0]   cnt;    // results due on a flush
		logic [HALF_W-1:0]   half;   // effective L
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_MAC,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} eng_state_t;

endpackage

// File: rtl/core/glb_front.sv
// Front end: accepts samples, tracks line position, issues commands.
module glb_front #(
	parameter int MAX_HALF_WIDTH = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [glb_pkg::HALF_W-1:0]    half_width,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  glb_pkg::in_beat_t             in_data,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output glb_pkg::cmd_t                 cmd
);
	import glb_pkg::*;

	logic [HALF_W-1:0] pos_q;
	logic [HALF_W-1:0] l_eff;
	logic [HALF_W-1:0] pos_c;
	logic [HALF_W:0]   cnt_w;
	logic [HALF_W-1:0] cnt;
	logic              accept;

	// effective half width: 0 acts as 1, clamp to MAX_HALF_WIDTH
	always_comb begin
		l_eff = (half_width == '0) ? HALF_W'(1) : half_width;
		if ({1'b0, l_eff} > (HALF_W+1)'(MAX_HALF_WIDTH))
			l_eff = HALF_W'(MAX_HALF_WIDTH);
	end

	// position clamp and sample count
	always_comb begin
		pos_c = (pos_q > l_eff) ? l_eff : pos_q;
		cnt_w = {1'b0, pos_c} + (HALF_W+1)'(1);
		cnt   = (cnt_w > {1'b0, l_eff}) ? l_eff : cnt_w[HALF_W-1:0];
	end

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid & cmd_ready;

	always_comb begin
		cmd.sample = in_data.sample;
		cmd.fill   = (pos_c == '0);
		cmd.last   = in_data.line_end;
		cmd.emit   = (cnt == l_eff);
		cmd.cnt    = cnt;
		cmd.half   = l_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= in_data.line_end ? '0 : cnt;
		end
	end

endmodule

// File: rtl/core/glb_cmd_fifo.sv
// Two-entry command queue between front end and engine.
module glb_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  glb_pkg::cmd_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output glb_pkg::cmd_t rd_data
);
	import glb_pkg::*;

	cmd_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/core/glb_engine.sv
// Engine: sample window, multiply-accumulate over taps, serial divide.
module glb_engine #(
	parameter int MAX_HALF_WIDTH = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [glb_pkg::WGT_W-1:0]     weights,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  glb_pkg::cmd_t                 cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output glb_pkg::out_beat_t            out_data
);
	import glb_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 2;
	localparam int IDX_W     = $clog2(WIN_DEPTH);

	eng_state_t         st_q, st_d;
	cmd_t               cmd_q;
	logic [SAMPLE_W-1:0] win_q [WIN_DEPTH];
	logic [HALF_W-1:0]  pad_q;
	logic [HALF_W-1:0]  rem_q;
	logic [TAP_W-1:0]   j_q;
	logic [2*SAMPLE_W-1:0] prod_s1;
	logic               pv_s1;
	logic [TOT_W-1:0]   tot_q;
	logic [ACC_W-1:0]   acc_q;
	logic [TOT_W-1:0]   r_q;
	logic [TAP_W-1:0]   bit_q;
	logic               oval_q;
	out_beat_t          out_q;

	logic [HALF_W-1:0]  pad_init;
	logic [TAP_W-1:0]   j1;
	logic [TAP_W-1:0]   d;
	logic [SAMPLE_W-1:0] w;
	logic [SAMPLE_W-1:0] tap;
	logic [TOT_W:0]     r_sh;
	logic               r_ge;
	logic               out_free;
	logic               pop;
	logic               do_shift;
	logic               mac_clr;

	assign pad_init = cmd.half - cmd.cnt;
	assign out_free = ~oval_q | out_ready;
	assign pop      = (st_q == ST_IDLE) & cmd_valid;

	// tap distance and weight
	always_comb begin
		j1  = j_q + TAP_W'(1);
		d   = (j1 > TAP_W'(cmd_q.half)) ? (j1 - TAP_W'(cmd_q.half))
		                               : (TAP_W'(cmd_q.half) - j1);
		w   = d[4] ? '0 : weights[{d[3:0], 3'b000} +: SAMPLE_W];
		tap = win_q[IDX_W'(j_q)];
	end

	// restoring divide step
	always_comb begin
		r_sh = {r_q, acc_q[ACC_W-1]};
		r_ge = (r_sh >= {1'b0, tot_q});
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.last)
						st_d = (pad_init != '0) ? ST_PAD : ST_MAC;
					else if (cmd.emit)
						st_d = ST_MAC;
				end
			end
			ST_PAD: begin
				if (pad_q == HALF_W'(1))
					st_d = ST_MAC;
			end
			ST_MAC: begin
				if (j_q == {cmd_q.half, 1'b0} - TAP_W'(1))
					st_d = ST_DRAIN;
			end
			ST_DRAIN: st_d = ST_DIV;
			ST_DIV: begin
				if (bit_q == TAP_W'(ACC_W - 1))
					st_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					st_d = (rem_q == HALF_W'(1)) ? ST_IDLE : ST_MAC;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd_ready = (st_q == ST_IDLE);
		do_shift  = (st_q == ST_PAD) ||
		            ((st_q == ST_OUT) && out_free && (rem_q != HALF_W'(1)));
		mac_clr   = (st_q != ST_MAC) && (st_d == ST_MAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	// sample window: flood on line start, else shift newest into index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				win_q[i] <= '0;
		end else if (pop && cmd.fill) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				win_q[i] <= cmd.sample;
		end else if (pop || do_shift) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				win_q[i] <= win_q[i-1];
			win_q[0] <= pop ? cmd.sample : cmd_q.sample;
		end
	end

	// command, pad and result counters
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
			pad_q <= pad_init;
			rem_q <= cmd.last ? cmd.cnt : HALF_W'(1);
		end else begin
			if (st_q == ST_PAD)
				pad_q <= pad_q - HALF_W'(1);
			if (st_q == ST_OUT && out_free)
				rem_q <= rem_q - HALF_W'(1);
		end
	end

	// multiply-accumulate and divide datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (mac_clr) begin
			pv_s1 <= 1'b0;
		end else if (st_q == ST_MAC) begin
			pv_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_clr) begin
			j_q   <= '0;
			acc_q <= '0;
			tot_q <= '0;
		end else begin
			unique case (st_q)
				ST_MAC: begin
					prod_s1 <= w * tap;
					tot_q   <= tot_q + TOT_W'(w);
					j_q     <= j_q + TAP_W'(1);
					if (pv_s1)
						acc_q <= acc_q + ACC_W'(prod_s1);
				end
				ST_DRAIN: begin
					acc_q <= acc_q + ACC_W'(prod_s1);
					r_q   <= '0;
					bit_q <= '0;
				end
				ST_DIV: begin
					r_q   <= r_ge ? TOT_W'(r_sh - {1'b0, tot_q}) : r_sh[TOT_W-1:0];
					acc_q <= {acc_q[ACC_W-2:0], r_ge};
					bit_q <= bit_q + TAP_W'(1);
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (st_q == ST_OUT && out_free) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && out_free) begin
			out_q.blurred      <= (tot_q == '0) ? '0 : acc_q[SAMPLE_W-1:0];
			out_q.last_of_line <= cmd_q.last && (rem_q == HALF_W'(1));
		end
	end

	assign out_valid = oval_q;
	assign out_data  = out_q;

endmodule

// File: rtl/core/gaussian_line_blur.sv
// L is the half width. Each result is worked out in turn by the single shared
// multiplier walking 2L taps and the one-bit-per-cycle 21-step divider; the engine
// takes no new command until it has issued every result of the last one. A line-end
// flush shifts the window L-n times before its n results. Input is taken while the
// two-entry command queue has room.
// Async active-low reset clears window, position and registers to their defaults (L=6).
module gaussian_line_blur #(
	parameter int MAX_HALF_WIDTH = 15
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [glb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [glb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  glb_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output glb_pkg::out_beat_t               out_data
);
	import glb_pkg::*;

	logic [HALF_W-1:0]     half_width_q;
	logic [CFG_DATA_W-1:0] weights_low_q;
	logic [CFG_DATA_W-1:0] weights_high_q;

	logic f_valid, f_ready, e_valid, e_ready;
	cmd_t f_cmd, e_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q   <= HALF_WIDTH_RST;
			weights_low_q  <= WEIGHTS_LOW_RST;
			weights_high_q <= WEIGHTS_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_WIDTH:   half_width_q   <= cfg_wdata[HALF_W-1:0];
				REG_WEIGHTS_LOW:  weights_low_q  <= cfg_wdata;
				REG_WEIGHTS_HIGH: weights_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	glb_front #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.half_width(half_width_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	glb_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data (f_cmd),
		.rd_valid(e_valid),
		.rd_ready(e_ready),
		.rd_data (e_cmd)
	);

	glb_engine #(.MAX_HALF_WIDTH(MAX_HALF_WIDTH)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.weights  ({weights_high_q, weights_low_q}),
		.cmd_valid(e_valid),
		.cmd_ready(e_ready),
		.cmd      (e_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
